FILE: rtl/software_breakpoint_table_assert.svh
// assertion macros for the software breakpoint table checker
// expects clk and arst_n in the scope of use
`ifndef SOFTWARE_BREAKPOINT_TABLE_ASSERT_SVH
`define SOFTWARE_BREAKPOINT_TABLE_ASSERT_SVH

// same-cycle implication
`define SBT_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SBT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/sbt_pkg.sv
// types and constants of the software breakpoint table
// no dependencies
package sbt_pkg;

	localparam logic [2:0] OP_ADD         = 3'd0;
	localparam logic [2:0] OP_DELETE      = 3'd1;
	localparam logic [2:0] OP_INCLUDE     = 3'd2;
	localparam logic [2:0] OP_EXCLUDE     = 3'd3;
	localparam logic [2:0] OP_CLEAR_SPACE = 3'd4;
	localparam logic [2:0] OP_CLEAR_ALL   = 3'd5;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_EXISTS    = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;
	localparam logic [1:0] ST_NOT_FOUND = 2'd3;

	localparam logic [7:0] TRAP_OPCODE = 8'hCC;

	typedef struct packed {
		logic [2:0]  operation;
		logic [15:0] space_id;
		logic [47:0] address;
		logic [7:0]  data_byte;
	} sbt_req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  out_byte;
		logic        hit;
		logic [15:0] entry_space;
		logic [47:0] entry_address;
		logic        last;
	} sbt_rsp_t;

	typedef struct packed {
		logic        valid;
		logic [15:0] space;
		logic [47:0] address;
		logic [7:0]  saved_byte;
	} sbt_entry_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_WALK,
		S_APPLY,
		S_RESP,
		S_DRAIN
	} sbt_state_t;

endpackage

FILE: rtl/sbt_cell.sv
// one slot of the breakpoint ring, shifts its entry to the neighbor
// depends on sbt_pkg
module sbt_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                shift_en,
	input  sbt_pkg::sbt_entry_t entry_in,
	output sbt_pkg::sbt_entry_t entry_out
);

	logic        valid_q;
	logic [15:0] space_q;
	logic [47:0] address_q;
	logic [7:0]  saved_byte_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift_en) begin
			valid_q <= entry_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (shift_en) begin
			space_q      <= entry_in.space;
			address_q    <= entry_in.address;
			saved_byte_q <= entry_in.saved_byte;
		end
	end

	assign entry_out.valid      = valid_q;
	assign entry_out.space      = space_q;
	assign entry_out.address    = address_q;
	assign entry_out.saved_byte = saved_byte_q;

endmodule

FILE: rtl/sbt_ctrl.sv
// sequencer of the breakpoint ring: walks the head slot, rewrites it, builds results
// depends on sbt_pkg
module sbt_ctrl #(
	parameter int ENTRIES = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  sbt_pkg::sbt_req_t   req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output sbt_pkg::sbt_rsp_t   rsp,
	input  sbt_pkg::sbt_entry_t head,
	output logic                shift_en,
	output sbt_pkg::sbt_entry_t wb
);

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

	sbt_pkg::sbt_state_t state_q, state_d;
	sbt_pkg::sbt_req_t   req_q;
	logic [IDX_W-1:0]    cnt_q;
	logic                match_q;
	logic [7:0]          match_byte_q;
	logic                free_q;
	logic [IDX_W-1:0]    free_idx_q;
	logic                pend_valid_q;
	sbt_pkg::sbt_rsp_t   pend_q;
	logic                out_valid_q;
	sbt_pkg::sbt_rsp_t   out_q;

	logic              accept;
	logic              op_known;
	logic              hit_now;
	logic              match_nx;
	logic              free_nx;
	logic              wrap;
	logic              out_free;
	logic              push;
	sbt_pkg::sbt_rsp_t push_data;
	sbt_pkg::sbt_rsp_t resp_d;
	sbt_pkg::sbt_rsp_t head_rsp;

	assign req_stall = (state_q != sbt_pkg::S_IDLE);
	assign accept    = req_valid && !req_stall;
	assign op_known  = (req.operation <= sbt_pkg::OP_CLEAR_ALL);
	assign hit_now   = head.valid && (head.space == req_q.space_id)
		&& (head.address == req_q.address);
	assign match_nx  = match_q || hit_now;
	assign free_nx   = free_q || !head.valid;
	assign wrap      = (cnt_q == LAST_IDX);
	assign out_free  = !out_valid_q || !rsp_stall;

	always_comb begin
		head_rsp               = '0;
		head_rsp.status        = sbt_pkg::ST_OK;
		head_rsp.out_byte      = head.saved_byte;
		head_rsp.hit           = 1'b1;
		head_rsp.entry_space   = head.space;
		head_rsp.entry_address = head.address;
	end

	// single result of every operation but clear all
	always_comb begin
		resp_d      = '0;
		resp_d.last = 1'b1;
		unique case (req_q.operation)
			sbt_pkg::OP_ADD: begin
				if (match_q) begin
					resp_d.status = sbt_pkg::ST_EXISTS;
					resp_d.hit    = 1'b1;
				end else if (free_q) begin
					resp_d.out_byte = sbt_pkg::TRAP_OPCODE;
				end else begin
					resp_d.status = sbt_pkg::ST_FULL;
				end
			end
			sbt_pkg::OP_DELETE: begin
				if (match_q) begin
					resp_d.out_byte = match_byte_q;
					resp_d.hit      = 1'b1;
				end else begin
					resp_d.status = sbt_pkg::ST_NOT_FOUND;
				end
			end
			sbt_pkg::OP_INCLUDE: begin
				resp_d.out_byte = match_q ? sbt_pkg::TRAP_OPCODE : req_q.data_byte;
				resp_d.hit      = match_q;
			end
			sbt_pkg::OP_EXCLUDE: begin
				resp_d.out_byte = match_q ? match_byte_q : req_q.data_byte;
				resp_d.hit      = match_q;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sbt_pkg::S_IDLE: begin
				if (accept && op_known) begin
					state_d = sbt_pkg::S_WALK;
				end
			end
			sbt_pkg::S_WALK: begin
				if (shift_en && wrap) begin
					if (req_q.operation == sbt_pkg::OP_CLEAR_ALL) begin
						state_d = sbt_pkg::S_DRAIN;
					end else if (req_q.operation == sbt_pkg::OP_ADD && !match_nx && free_nx) begin
						state_d = sbt_pkg::S_APPLY;
					end else begin
						state_d = sbt_pkg::S_RESP;
					end
				end
			end
			sbt_pkg::S_APPLY: begin
				if (wrap) begin
					state_d = sbt_pkg::S_RESP;
				end
			end
			sbt_pkg::S_RESP, sbt_pkg::S_DRAIN: begin
				if (out_free) begin
					state_d = sbt_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = sbt_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		shift_en  = 1'b0;
		wb        = head;
		push      = 1'b0;
		push_data = resp_d;
		unique case (state_q)
			sbt_pkg::S_WALK: begin
				if (req_q.operation == sbt_pkg::OP_CLEAR_ALL) begin
					// previous restore leaves only once the next one is known
					if (head.valid && pend_valid_q) begin
						shift_en  = out_free;
						push      = out_free;
						push_data = pend_q;
					end else begin
						shift_en = 1'b1;
					end
					if (head.valid) begin
						wb.valid = 1'b0;
					end
				end else begin
					shift_en = 1'b1;
					if (hit_now && req_q.operation == sbt_pkg::OP_DELETE) begin
						wb.valid = 1'b0;
					end
					if (hit_now && req_q.operation == sbt_pkg::OP_INCLUDE) begin
						wb.saved_byte = req_q.data_byte;
					end
					if (req_q.operation == sbt_pkg::OP_CLEAR_SPACE && head.valid
						&& head.space == req_q.space_id) begin
						wb.valid = 1'b0;
					end
				end
			end
			sbt_pkg::S_APPLY: begin
				shift_en = 1'b1;
				if (cnt_q == free_idx_q) begin
					wb.valid      = 1'b1;
					wb.space      = req_q.space_id;
					wb.address    = req_q.address;
					wb.saved_byte = req_q.data_byte;
				end
			end
			sbt_pkg::S_RESP: begin
				push = out_free;
			end
			sbt_pkg::S_DRAIN: begin
				push = out_free;
				if (pend_valid_q) begin
					push_data      = pend_q;
					push_data.last = 1'b1;
				end else begin
					push_data      = '0;
					push_data.last = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= sbt_pkg::S_IDLE;
			cnt_q        <= '0;
			match_q      <= 1'b0;
			free_q       <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				cnt_q        <= '0;
				match_q      <= 1'b0;
				free_q       <= 1'b0;
				pend_valid_q <= 1'b0;
			end else if (shift_en) begin
				cnt_q <= wrap ? '0 : cnt_q + 1'b1;
				if (state_q == sbt_pkg::S_WALK) begin
					match_q <= match_nx;
					free_q  <= free_nx;
					if (head.valid) begin
						pend_valid_q <= 1'b1;
					end
				end
			end
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		if (shift_en && state_q == sbt_pkg::S_WALK) begin
			if (hit_now) begin
				match_byte_q <= head.saved_byte;
			end
			if (!free_q && !head.valid) begin
				free_idx_q <= cnt_q;
			end
			if (head.valid) begin
				pend_q <= head_rsp;
			end
		end
		if (push) begin
			out_q <= push_data;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule

FILE: rtl/software_breakpoint_table.sv
// software breakpoint table: ring of slot cells walked past one head slot
// depends on sbt_pkg, sbt_cell, sbt_ctrl
//
// channel   signals                      payload
// request   req_valid / req_stall        req (sbt_req_t)
// response  rsp_valid / rsp_stall        rsp (sbt_rsp_t)
//
// every known operation rotates the whole ring once; an unknown operation is accepted with no response
// a new add rotates twice, once to search and once to write
// clear all gives one transaction per valid slot (one empty final one if none), ring pauses while rsp_stall holds
// reset empties the table at once; slot payload is not cleared
// req_stall is high from acceptance until the last response is registered
module software_breakpoint_table #(
	parameter int ENTRIES = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  sbt_pkg::sbt_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output sbt_pkg::sbt_rsp_t rsp
);

	sbt_pkg::sbt_entry_t ring [ENTRIES];
	sbt_pkg::sbt_entry_t wb;
	logic                shift_en;

	sbt_ctrl #(
		.ENTRIES(ENTRIES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.head      (ring[0]),
		.shift_en  (shift_en),
		.wb        (wb)
	);

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		if (i == ENTRIES - 1) begin : g_tail
			sbt_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.shift_en  (shift_en),
				.entry_in  (wb),
				.entry_out (ring[i])
			);
		end else begin : g_body
			sbt_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.shift_en  (shift_en),
				.entry_in  (ring[i+1]),
				.entry_out (ring[i])
			);
		end
	end

endmodule

FILE: rtl/sbt_checker.sv
// port-level checks of the software breakpoint table, bound to the top level
// depends on sbt_pkg, software_breakpoint_table_assert.svh
`include "software_breakpoint_table_assert.svh"

module sbt_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_stall,
	input sbt_pkg::sbt_req_t req,
	input logic              rsp_valid,
	input logic              rsp_stall,
	input sbt_pkg::sbt_rsp_t rsp
);

	`SBT_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall,
		rsp_valid && $stable(rsp), "stalled response changed")
	`SBT_ASSERT_NEXT(a_busy_after_req,
		req_valid && !req_stall && req.operation <= sbt_pkg::OP_CLEAR_ALL,
		req_stall, "known operation did not make the table busy")
	`SBT_ASSERT_IMPLY(a_restore_shape, rsp_valid && !rsp.last,
		rsp.hit && rsp.status == sbt_pkg::ST_OK, "non-final response is not a restore")
	`SBT_ASSERT_IMPLY(a_not_found_shape, rsp_valid && rsp.status == sbt_pkg::ST_NOT_FOUND,
		!rsp.hit && rsp.out_byte == 8'd0, "not found response carries data")

endmodule

bind software_breakpoint_table sbt_checker u_sbt_checker (.*);
